// ===== src/tlm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlm_pkg: shared types and constants
// Command, event and mode codes, character codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package tlm_pkg;

    localparam int unsigned PROGRAM_DEPTH_DEF = 4096;
    localparam int unsigned CELL_DEPTH_DEF    = 1024;
    localparam int unsigned STEP_LIMIT        = 4000000;
    localparam int unsigned BUDGET_W          = $clog2(STEP_LIMIT + 1);
    localparam int unsigned NUM_ARGS          = 7;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_START  = 2'd1,
        CMD_RESUME = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        EV_WRITE   = 3'd0,
        EV_READ    = 3'd1,
        EV_SYSCALL = 3'd2,
        EV_LOAD    = 3'd3,
        EV_HALT    = 3'd4,
        EV_FAULT   = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WAIT_WRITE,
        MODE_WAIT_READ,
        MODE_WAIT_SYSCALL,
        MODE_WAIT_LOAD,
        MODE_HALTED,
        MODE_FAULTED
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_FETCH,
        S_DECODE,
        S_EQ_RD,
        S_EQ_CHK,
        S_EQ_END,
        S_FWD,
        S_FWD_CHK,
        S_BWD,
        S_BWD_CHK,
        S_SYS_RD,
        S_SYS_CAP
    } t_state;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_COPY  = 8'h3D;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_SYS   = 8'h21;
    localparam logic [7:0] CH_LOAD  = 8'h2A;

    typedef struct packed {
        logic   append;
        logic   clr_init;
        logic   clr_step;
        logic   run_init;
        logic   fetch;
        logic   ip_inc;
        logic   ip_from_p;
        logic   ip_from_p1;
        logic   cell_inc;
        logic   cell_dec;
        logic   cp_inc;
        logic   cp_dec;
        logic   eq_init;
        logic   eq_rd;
        logic   eq_step;
        logic   eq_wr;
        logic   scan_init;
        logic   fwd_step;
        logic   bwd_step;
        logic   nest_inc;
        logic   nest_dec;
        logic   resp_wr;
        logic   resp_sext;
        logic   sys_init;
        logic   sys_rd;
        logic   sys_cap;
        logic   budget_dec;
        logic   out_load;
        t_event out_ev;
    } t_dp_cmd;

    typedef struct packed {
        logic       plen_full;
        logic       ip_at_end;
        logic       budget_zero;
        logic [7:0] prog_byte;
        logic       val_zero;
        logic       cp_last;
        logic       cp_zero;
        logic       eq_more;
        logic       eq_oob;
        logic       fwd_end;
        logic       p_zero;
        logic       nest_one;
        logic       clr_done;
        logic       sys_done;
    } t_dp_status;

endpackage

// ===== src/tlm_datapath.sv =====
// ----------------------------------------------------------------------------
// tlm_datapath: stores, pointers and result registers
// Program memory, cell memory, scan/copy counters, watchdog, result payload.
// ----------------------------------------------------------------------------
module tlm_datapath import tlm_pkg::*; #(
    parameter int unsigned PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
    parameter int unsigned CELL_DEPTH    = CELL_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic [7:0]  i_program_byte,
    input  logic [63:0] i_response_value,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_out_byte,
    output logic [63:0] o_request_word0,
    output logic [63:0] o_request_word1,
    output logic [63:0] o_request_word2,
    output logic [63:0] o_request_word3,
    output logic [63:0] o_request_word4,
    output logic [63:0] o_request_word5,
    output logic [63:0] o_request_word6
);

    localparam int unsigned PAW = $clog2(PROGRAM_DEPTH);
    localparam int unsigned IPW = $clog2(PROGRAM_DEPTH + 1);
    localparam int unsigned CPW = $clog2(CELL_DEPTH);
    localparam int unsigned TW  = ((IPW > CPW) ? IPW : CPW) + 1;

    logic [7:0]  r_prog_mem [PROGRAM_DEPTH];
    logic [63:0] r_cell_mem [CELL_DEPTH];

    logic [63:0]         r_init_word;
    logic [IPW-1:0]      r_plen, r_ip, r_p, r_cnt, r_nest;
    logic [CPW-1:0]      r_cp, r_clr;
    logic [BUDGET_W-1:0] r_budget;
    logic [7:0]          r_prog_q;
    logic [63:0]         r_cell_q;
    logic [2:0]          r_k;
    logic                r_k_ok;
    logic [2:0]          r_ev;
    logic [7:0]          r_byte;
    logic [63:0]         r_w [NUM_ARGS];

    logic           prog_re;
    logic [IPW-1:0] prog_ra;
    logic           cell_re, cell_we;
    logic [CPW-1:0] cell_ra, cell_wa;
    logic [63:0]    cell_wd;
    logic [TW-1:0]  target, sys_addr;

    assign target   = TW'(r_cp) + TW'(r_cnt);
    assign sys_addr = TW'(r_cp) + TW'(r_k);

    // program read address
    always_comb begin
        prog_re = 1'b1;
        prog_ra = r_ip;
        priority if (i_cmd.fetch) begin
            prog_ra = r_ip;
        end else if (i_cmd.eq_rd) begin
            prog_ra = r_p;
        end else if (i_cmd.fwd_step) begin
            prog_ra = r_p + IPW'(1);
        end else if (i_cmd.bwd_step) begin
            prog_ra = r_p - IPW'(1);
        end else begin
            prog_re = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (r_plen < IPW'(PROGRAM_DEPTH))) begin
            r_prog_mem[r_plen[PAW-1:0]] <= i_program_byte;
        end
        if (prog_re) begin
            r_prog_q <= r_prog_mem[prog_ra[PAW-1:0]];
        end
    end

    // cell port: one write, one registered read
    always_comb begin
        cell_re = i_cmd.fetch || i_cmd.sys_rd;
        cell_ra = i_cmd.sys_rd ? sys_addr[CPW-1:0] : r_cp;
        cell_we = 1'b1;
        cell_wa = r_cp;
        cell_wd = r_cell_q;
        priority if (i_cmd.clr_step) begin
            cell_wa = r_clr;
            cell_wd = (r_clr == '0) ? r_init_word : 64'd0;
        end else if (i_cmd.cell_inc) begin
            cell_wd = r_cell_q + 64'd1;
        end else if (i_cmd.cell_dec) begin
            cell_wd = r_cell_q - 64'd1;
        end else if (i_cmd.eq_wr) begin
            cell_wa = target[CPW-1:0];
        end else if (i_cmd.resp_wr) begin
            cell_wd = i_cmd.resp_sext ? {{56{i_response_value[7]}}, i_response_value[7:0]}
                                      : i_response_value;
        end else begin
            cell_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cell_mem[cell_wa] <= cell_wd;
        end
        if (cell_re) begin
            r_cell_q <= r_cell_mem[cell_ra];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_word <= 64'd0;
            r_plen      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_init_word <= i_cfg_wr_data;
            end
            if (i_cmd.append && (r_plen < IPW'(PROGRAM_DEPTH))) begin
                r_plen <= r_plen + IPW'(1);
            end
        end
    end

    // pointers and counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_init) begin
            r_clr <= CPW'(CELL_DEPTH - 1);
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr - CPW'(1);
        end

        if (i_cmd.run_init) begin
            r_ip <= '0;
            r_cp <= CPW'(1);
        end else begin
            if (i_cmd.ip_inc) begin
                r_ip <= r_ip + IPW'(1);
            end else if (i_cmd.ip_from_p) begin
                r_ip <= r_p;
            end else if (i_cmd.ip_from_p1) begin
                r_ip <= r_p + IPW'(1);
            end
            if (i_cmd.cp_inc) begin
                r_cp <= r_cp + CPW'(1);
            end else if (i_cmd.cp_dec) begin
                r_cp <= r_cp - CPW'(1);
            end
        end

        if (i_cmd.run_init) begin
            r_budget <= BUDGET_W'(STEP_LIMIT);
        end else if (i_cmd.budget_dec) begin
            r_budget <= r_budget - BUDGET_W'(1);
        end

        if (i_cmd.eq_init) begin
            r_cnt <= IPW'(1);
            r_p   <= r_ip + IPW'(1);
        end else if (i_cmd.eq_step) begin
            r_cnt <= r_cnt + IPW'(1);
            r_p   <= r_p + IPW'(1);
        end else if (i_cmd.scan_init) begin
            r_p <= r_ip;
        end else if (i_cmd.fwd_step) begin
            r_p <= r_p + IPW'(1);
        end else if (i_cmd.bwd_step) begin
            r_p <= r_p - IPW'(1);
        end

        if (i_cmd.scan_init) begin
            r_nest <= IPW'(1);
        end else if (i_cmd.nest_inc) begin
            r_nest <= r_nest + IPW'(1);
        end else if (i_cmd.nest_dec) begin
            r_nest <= r_nest - IPW'(1);
        end

        if (i_cmd.sys_init) begin
            r_k <= 3'd0;
        end else if (i_cmd.sys_cap) begin
            r_k <= r_k + 3'd1;
        end
        if (i_cmd.sys_rd) begin
            r_k_ok <= sys_addr < TW'(CELL_DEPTH);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.sys_cap) begin
            r_w[r_k] <= r_k_ok ? r_cell_q : 64'd0;
        end
        if (i_cmd.out_load) begin
            r_ev   <= i_cmd.out_ev;
            r_byte <= (i_cmd.out_ev == EV_WRITE) ? r_cell_q[7:0] : 8'd0;
            if (i_cmd.out_ev != EV_SYSCALL) begin
                for (int i = 0; i < NUM_ARGS; i++) begin
                    r_w[i] <= 64'd0;
                end
                if (i_cmd.out_ev == EV_LOAD) begin
                    r_w[0] <= r_cell_q;
                end
            end
        end
    end

    assign o_event_res     = r_ev;
    assign o_out_byte      = r_byte;
    assign o_request_word0 = r_w[0];
    assign o_request_word1 = r_w[1];
    assign o_request_word2 = r_w[2];
    assign o_request_word3 = r_w[3];
    assign o_request_word4 = r_w[4];
    assign o_request_word5 = r_w[5];
    assign o_request_word6 = r_w[6];

    always_comb begin
        o_status.plen_full   = r_plen >= IPW'(PROGRAM_DEPTH);
        o_status.ip_at_end   = r_ip >= r_plen;
        o_status.budget_zero = r_budget == '0;
        o_status.prog_byte   = r_prog_q;
        o_status.val_zero    = r_cell_q == 64'd0;
        o_status.cp_last     = (TW'(r_cp) + TW'(1)) >= TW'(CELL_DEPTH);
        o_status.cp_zero     = r_cp == '0;
        o_status.eq_more     = r_p < r_plen;
        o_status.eq_oob      = target >= TW'(CELL_DEPTH);
        o_status.fwd_end     = ({1'b0, r_p} + {{IPW{1'b0}}, 1'b1}) >= {1'b0, r_plen};
        o_status.p_zero      = r_p == '0;
        o_status.nest_one    = r_nest == IPW'(1);
        o_status.clr_done    = r_clr == '0;
        o_status.sys_done    = r_k == 3'(NUM_ARGS - 1);
    end

endmodule

// ===== src/tlm_controller.sv =====
// ----------------------------------------------------------------------------
// tlm_controller: run sequencer
// Handshakes, run mode, and the step sequence over the datapath.
// ----------------------------------------------------------------------------
module tlm_controller import tlm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) &&
                         (!r_out_valid || (t_cmd'(i_command) == CMD_APPEND));
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.out_ev = EV_HALT;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_command))
                        CMD_APPEND: o_cmd.append = 1'b1;
                        CMD_START: begin
                            o_cmd.clr_init = 1'b1;
                            o_cmd.run_init = 1'b1;
                            n_mode  = MODE_IDLE;
                            n_state = S_CLEAR;
                        end
                        CMD_RESUME: begin
                            unique case (r_mode)
                                MODE_WAIT_WRITE, MODE_WAIT_READ,
                                MODE_WAIT_SYSCALL, MODE_WAIT_LOAD: begin
                                    o_cmd.resp_wr   = r_mode != MODE_WAIT_WRITE;
                                    o_cmd.resp_sext = r_mode == MODE_WAIT_READ;
                                    o_cmd.ip_inc    = 1'b1;
                                    n_mode  = MODE_IDLE;
                                    n_state = S_FETCH;
                                end
                                default: ;
                            endcase
                        end
                        CMD_NONE: ;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_status.ip_at_end) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ev   = EV_HALT;
                    n_out_valid    = 1'b1;
                    n_mode         = MODE_HALTED;
                    n_state        = S_IDLE;
                end else if (i_status.budget_zero) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ev   = EV_FAULT;
                    n_out_valid    = 1'b1;
                    n_mode         = MODE_FAULTED;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.fetch      = 1'b1;
                    o_cmd.budget_dec = 1'b1;
                    n_state          = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FETCH;
                unique case (i_status.prog_byte)
                    CH_PLUS: begin
                        o_cmd.cell_inc = 1'b1;
                        o_cmd.ip_inc   = 1'b1;
                    end
                    CH_MINUS: begin
                        o_cmd.cell_dec = 1'b1;
                        o_cmd.ip_inc   = 1'b1;
                    end
                    CH_RIGHT: begin
                        if (i_status.cp_last) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_ev   = EV_FAULT;
                            n_out_valid    = 1'b1;
                            n_mode         = MODE_FAULTED;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.cp_inc = 1'b1;
                            o_cmd.ip_inc = 1'b1;
                        end
                    end
                    CH_LEFT: begin
                        if (i_status.cp_zero) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_ev   = EV_FAULT;
                            n_out_valid    = 1'b1;
                            n_mode         = MODE_FAULTED;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.cp_dec = 1'b1;
                            o_cmd.ip_inc = 1'b1;
                        end
                    end
                    CH_COPY: begin
                        o_cmd.eq_init = 1'b1;
                        n_state       = S_EQ_RD;
                    end
                    CH_OPEN: begin
                        if (i_status.val_zero) begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_FWD;
                        end else begin
                            o_cmd.ip_inc = 1'b1;
                        end
                    end
                    CH_CLOSE: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_BWD;
                    end
                    CH_OUT: begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_ev   = EV_WRITE;
                        n_out_valid    = 1'b1;
                        n_mode         = MODE_WAIT_WRITE;
                        n_state        = S_IDLE;
                    end
                    CH_IN: begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_ev   = EV_READ;
                        n_out_valid    = 1'b1;
                        n_mode         = MODE_WAIT_READ;
                        n_state        = S_IDLE;
                    end
                    CH_LOAD: begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_ev   = EV_LOAD;
                        n_out_valid    = 1'b1;
                        n_mode         = MODE_WAIT_LOAD;
                        n_state        = S_IDLE;
                    end
                    CH_SYS: begin
                        o_cmd.sys_init = 1'b1;
                        n_state        = S_SYS_RD;
                    end
                    default: o_cmd.ip_inc = 1'b1;
                endcase
            end
            S_EQ_RD: begin
                if (i_status.eq_more) begin
                    o_cmd.eq_rd = 1'b1;
                    n_state     = S_EQ_CHK;
                end else begin
                    n_state = S_EQ_END;
                end
            end
            S_EQ_CHK: begin
                if (i_status.prog_byte == CH_COPY) begin
                    o_cmd.eq_step = 1'b1;
                    n_state       = S_EQ_RD;
                end else begin
                    n_state = S_EQ_END;
                end
            end
            S_EQ_END: begin
                if (i_status.eq_oob) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ev   = EV_FAULT;
                    n_out_valid    = 1'b1;
                    n_mode         = MODE_FAULTED;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.eq_wr     = 1'b1;
                    o_cmd.ip_from_p = 1'b1;
                    n_state         = S_FETCH;
                end
            end
            S_FWD: begin
                if (i_status.fwd_end || i_status.budget_zero) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ev   = EV_FAULT;
                    n_out_valid    = 1'b1;
                    n_mode         = MODE_FAULTED;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.fwd_step   = 1'b1;
                    o_cmd.budget_dec = 1'b1;
                    n_state          = S_FWD_CHK;
                end
            end
            S_FWD_CHK: begin
                n_state = S_FWD;
                if (i_status.prog_byte == CH_OPEN) begin
                    o_cmd.nest_inc = 1'b1;
                end else if (i_status.prog_byte == CH_CLOSE) begin
                    if (i_status.nest_one) begin
                        o_cmd.ip_from_p1 = 1'b1;
                        n_state          = S_FETCH;
                    end else begin
                        o_cmd.nest_dec = 1'b1;
                    end
                end
            end
            S_BWD: begin
                if (i_status.p_zero || i_status.budget_zero) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ev   = EV_FAULT;
                    n_out_valid    = 1'b1;
                    n_mode         = MODE_FAULTED;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.bwd_step   = 1'b1;
                    o_cmd.budget_dec = 1'b1;
                    n_state          = S_BWD_CHK;
                end
            end
            S_BWD_CHK: begin
                n_state = S_BWD;
                if (i_status.prog_byte == CH_CLOSE) begin
                    o_cmd.nest_inc = 1'b1;
                end else if (i_status.prog_byte == CH_OPEN) begin
                    if (i_status.nest_one) begin
                        o_cmd.ip_from_p = 1'b1;
                        n_state         = S_FETCH;
                    end else begin
                        o_cmd.nest_dec = 1'b1;
                    end
                end
            end
            S_SYS_RD: begin
                o_cmd.sys_rd = 1'b1;
                n_state      = S_SYS_CAP;
            end
            S_SYS_CAP: begin
                o_cmd.sys_cap = 1'b1;
                if (i_status.sys_done) begin
                    n_state = S_SYS_CAP;
                    n_state = S_IDLE;
                    n_mode  = MODE_WAIT_SYSCALL;
                    n_out_valid = 1'b1;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ev   = EV_SYSCALL;
                end else begin
                    n_state = S_SYS_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== src/tape_language_machine.sv =====
// ----------------------------------------------------------------------------
// tape_language_machine: bracket-loop tape interpreter, 64-bit cells
// Loads program bytes, runs them over a cell store, stops on I/O requests.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_ready     | command, program byte, response
//  out     | output    | o_out_valid / i_out_ready   | event, byte, seven request words
//  cfg     | input     | i_cfg_wr_en (no wait)       | initial word for cell zero
//
//  Start sweeps the cell memory, then runs each program byte as a fetch and a
//  decode state; a bracket scan steps and checks each byte passed (single
//  program memory read port). A syscall request reads and captures seven
//  cells in turn. Start and resume are taken only once the last result has
//  left; appends are taken any time the sequencer is idle.
//  Reset is synchronous, active low; cells are written by the start sweep.
// ----------------------------------------------------------------------------
module tape_language_machine import tlm_pkg::*; #(
    parameter int unsigned PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
    parameter int unsigned CELL_DEPTH    = CELL_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_program_byte,
    input  logic [63:0] i_response_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_out_byte,
    output logic [63:0] o_request_word0,
    output logic [63:0] o_request_word1,
    output logic [63:0] o_request_word2,
    output logic [63:0] o_request_word3,
    output logic [63:0] o_request_word4,
    output logic [63:0] o_request_word5,
    output logic [63:0] o_request_word6
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: handshakes, run mode, step order
    tlm_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // memories, pointers, watchdog, result registers
    tlm_datapath #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .CELL_DEPTH    (CELL_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_program_byte   (i_program_byte),
        .i_response_value (i_response_value),
        .o_event_res      (o_event_res),
        .o_out_byte       (o_out_byte),
        .o_request_word0  (o_request_word0),
        .o_request_word1  (o_request_word1),
        .o_request_word2  (o_request_word2),
        .o_request_word3  (o_request_word3),
        .o_request_word4  (o_request_word4),
        .o_request_word5  (o_request_word5),
        .o_request_word6  (o_request_word6)
    );

endmodule

// ===== test/tlm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlm_checker: result predictor and scoreboard for tape_language_machine
// Snoops config, input and output channels, runs its own interpreter on each
// start/resume item, queues the expected result and compares field by field.
// ----------------------------------------------------------------------------
module tlm_checker import tlm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  prog_byte,
    input  logic [63:0] response,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  ev_code,
    input  logic [7:0]  out_byte,
    input  logic [63:0] w0, w1, w2, w3, w4, w5, w6,
    output int          errors,
    output int          n_waiting
);

    localparam int unsigned PDEPTH = PROGRAM_DEPTH_DEF;
    localparam int unsigned TDEPTH = CELL_DEPTH_DEF;

    typedef struct packed {
        t_event           ev;
        logic [7:0]       ob;
        logic [6:0][63:0] words;
    } t_outcome;

    logic [7:0]  prog_mem [PDEPTH];
    logic [63:0] tape [TDEPTH];
    int unsigned plen, ip, tp;
    t_mode       mode;
    logic [63:0] init_word;
    t_outcome    expected_q [$];

    function automatic t_outcome outcome(t_event e);
        t_outcome r;
        r = '0;
        r.ev = e;
        if (e == EV_WRITE) r.ob = tape[tp][7:0];
        if (e == EV_LOAD) r.words[0] = tape[tp];
        if (e == EV_SYSCALL) begin
            for (int j = 0; j < NUM_ARGS; j++)
                r.words[j] = (tp + j < TDEPTH) ? tape[tp + j] : 64'd0;
        end
        return r;
    endfunction

    function automatic t_outcome stop_fault();
        mode = MODE_FAULTED;
        return outcome(EV_FAULT);
    endfunction

    // runs until a request, the end of the program or a fault
    function automatic t_outcome interpret();
        int unsigned budget, p, nest, count;
        logic [7:0]  c;
        budget = STEP_LIMIT;
        while (1'b1) begin
            if (ip >= plen) begin
                mode = MODE_HALTED;
                return outcome(EV_HALT);
            end
            if (budget == 0) return stop_fault();
            budget--;
            c = prog_mem[ip];
            case (c)
                CH_PLUS: begin
                    tape[tp] = tape[tp] + 64'd1;
                    ip++;
                end
                CH_MINUS: begin
                    tape[tp] = tape[tp] - 64'd1;
                    ip++;
                end
                CH_RIGHT: begin
                    if (tp + 1 >= TDEPTH) return stop_fault();
                    tp++;
                    ip++;
                end
                CH_LEFT: begin
                    if (tp == 0) return stop_fault();
                    tp--;
                    ip++;
                end
                CH_COPY: begin
                    count = 1;
                    p = ip + 1;
                    while (p < plen && prog_mem[p] == CH_COPY) begin
                        count++;
                        p++;
                    end
                    if (tp + count >= TDEPTH) return stop_fault();
                    tape[tp + count] = tape[tp];
                    ip = p;
                end
                CH_OPEN: begin
                    if (tape[tp] == 64'd0) begin
                        p = ip;
                        nest = 1;
                        while (nest != 0) begin
                            p++;
                            if (p >= plen) return stop_fault();
                            if (budget == 0) return stop_fault();
                            budget--;
                            if (prog_mem[p] == CH_OPEN) nest++;
                            else if (prog_mem[p] == CH_CLOSE) nest--;
                        end
                        ip = p + 1;
                    end else begin
                        ip++;
                    end
                end
                CH_CLOSE: begin
                    p = ip;
                    nest = 1;
                    while (nest != 0) begin
                        if (p == 0) return stop_fault();
                        p--;
                        if (budget == 0) return stop_fault();
                        budget--;
                        if (prog_mem[p] == CH_OPEN) nest--;
                        else if (prog_mem[p] == CH_CLOSE) nest++;
                    end
                    ip = p;
                end
                CH_OUT: begin
                    mode = MODE_WAIT_WRITE;
                    return outcome(EV_WRITE);
                end
                CH_IN: begin
                    mode = MODE_WAIT_READ;
                    return outcome(EV_READ);
                end
                CH_SYS: begin
                    mode = MODE_WAIT_SYSCALL;
                    return outcome(EV_SYSCALL);
                end
                CH_LOAD: begin
                    mode = MODE_WAIT_LOAD;
                    return outcome(EV_LOAD);
                end
                default: ip++;
            endcase
        end
        return stop_fault();
    endfunction

    task automatic report(string what, logic [63:0] seen, logic [63:0] want);
        $display("%0t tlm_checker: %s got %h expected %h", $time, what, seen, want);
        errors++;
    endtask

    always @(posedge clk) begin : watch
        t_outcome want, seen;
        if (!rst_n) begin
            plen = 0;
            ip = 0;
            tp = 1;
            mode = MODE_IDLE;
            init_word = '0;
            foreach (tape[i]) tape[i] = '0;
            expected_q.delete();
            errors = 0;
        end else begin
            if (cfg_wr_en) init_word = cfg_wr_data;
            if (in_valid && in_ready) begin
                case (t_cmd'(command))
                    CMD_APPEND: begin
                        if (plen < PDEPTH) begin
                            prog_mem[plen] = prog_byte;
                            plen++;
                        end
                    end
                    CMD_START: begin
                        foreach (tape[i]) tape[i] = '0;
                        tape[0] = init_word;
                        tp = 1;
                        ip = 0;
                        expected_q.push_back(interpret());
                    end
                    CMD_RESUME: begin
                        if (mode == MODE_WAIT_WRITE || mode == MODE_WAIT_READ ||
                            mode == MODE_WAIT_SYSCALL || mode == MODE_WAIT_LOAD) begin
                            if (mode == MODE_WAIT_READ)
                                tape[tp] = {{56{response[7]}}, response[7:0]};
                            else if (mode != MODE_WAIT_WRITE)
                                tape[tp] = response;
                            ip++;
                            expected_q.push_back(interpret());
                        end
                    end
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                seen.ev = t_event'(ev_code);
                seen.ob = out_byte;
                seen.words = {w6, w5, w4, w3, w2, w1, w0};
                if (expected_q.size() == 0) begin
                    report("unexpected result, event", 64'(ev_code), '0);
                end else begin
                    want = expected_q.pop_front();
                    if (seen.ev != want.ev) report("event_res", 64'(seen.ev), 64'(want.ev));
                    if (seen.ob != want.ob) report("out_byte", 64'(seen.ob), 64'(want.ob));
                    for (int j = 0; j < NUM_ARGS; j++) begin
                        if (seen.words[j] != want.words[j])
                            report($sformatf("request_word%0d", j), seen.words[j],
                                   want.words[j]);
                    end
                end
            end
        end
        n_waiting <= expected_q.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for tape_language_machine
// Builds a program out of well-formed random fragments, runs and resumes it
// under random idling on both channels, then drives the fault cases and a
// full program store. tlm_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import tlm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_NONE;
    logic [7:0]  prog_byte = '0;
    logic [63:0] response = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  ev_code;
    logic [7:0]  out_byte;
    logic [63:0] w0, w1, w2, w3, w4, w5, w6;
    int          errors;
    int          n_waiting;

    // stimulus bookkeeping
    int          items = 0;       // items accepted on the input channel
    int          filled = 0;      // program bytes appended
    bit          calm = 1'b0;     // no idling on either side once set
    int          stall_left = 0;
    t_event      last_ev = EV_HALT;

    tape_language_machine dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command       (command),
        .i_program_byte  (prog_byte),
        .i_response_value(response),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_event_res     (ev_code),
        .o_out_byte      (out_byte),
        .o_request_word0 (w0),
        .o_request_word1 (w1),
        .o_request_word2 (w2),
        .o_request_word3 (w3),
        .o_request_word4 (w4),
        .o_request_word5 (w5),
        .o_request_word6 (w6)
    );

    tlm_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .prog_byte  (prog_byte),
        .response   (response),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ev_code    (ev_code),
        .out_byte   (out_byte),
        .w0(w0), .w1(w1), .w2(w2), .w3(w3), .w4(w4), .w5(w5), .w6(w6),
        .errors     (errors),
        .n_waiting  (n_waiting)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // result side: random stall bursts until the calm tail
    always @(negedge clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (!calm && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 8);
        out_ready <= (stall_left == 0);
    end

    // last result taken, used to run a program through to its end
    always @(posedge clk) begin
        if (out_valid && out_ready) last_ev <= t_event'(ev_code);
    end

    initial begin
        #100_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // response words biased toward the sign-extension and wrap edges
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'h80;
            3:       return 64'($urandom_range(0, 20));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic string rep(string s, int n);
        string r;
        r = "";
        repeat (n) r = {r, s};
        return r;
    endfunction

    // one item, held until accepted; an optional idle burst goes first
    task automatic put(t_cmd c, logic [7:0] b, logic [63:0] v);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid = 1'b1;
        command = c;
        prog_byte = b;
        response = v;
        do @(posedge clk); while (!in_ready);
        items++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) put(CMD_APPEND, s[i], rand_word());
        filled += s.len();
    endtask

    task automatic wait_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (n_waiting != 0) @(negedge clk);
    endtask

    // idle before a register write; appends and ignored resumes give no result
    task automatic set_init(logic [63:0] v);
        wait_results();
        repeat (16) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // start, then answer every request until halt or fault
    task automatic run_through(bit rnd, logic [63:0] ans);
        int n;
        put(CMD_START, 8'($urandom), rand_word());
        wait_results();
        n = 0;
        while (!(last_ev == EV_HALT || last_ev == EV_FAULT) && n < 3000) begin
            put(CMD_RESUME, 8'($urandom), rnd ? rand_word() : ans);
            wait_results();
            n++;
        end
    endtask

    // Program fragments. Loops only ever work on fresh cells: a loop first
    // steps eight cells right, past anything a copy run (at most seven
    // ahead) or a loop body may have touched, so every loop terminates.
    task automatic add_fragment();
        string s, io, opts, inner;
        logic [7:0] junk;
        int k;
        io = ".,*!";
        opts = "+-=.*";
        s = "";
        case ($urandom_range(0, 9))
            0: s = rep("+", $urandom_range(1, 5));
            1: s = {"+", rep("-", $urandom_range(1, 3))};
            2: s = {rep("=", $urandom_range(1, 7)), "+"};    // closes the copy run
            4: begin
                k = $urandom_range(0, 5);
                s = (k == 5) ? "<>" : {"<", opts.substr(k, k), ">"};
            end
            5: begin
                case ($urandom_range(0, 3))
                    0:       inner = "";
                    1:       inner = ".";
                    2:       inner = ">+<";
                    default: inner = "[-]";
                endcase
                s = {">>>>>>>>", rep("+", $urandom_range(1, 6)), "[-", inner, "]"};
            end
            6: s = ">>>>>>>>[+.[,]*]";                     // skipped, nested scan
            7: begin
                do junk = 8'($urandom); while (junk == CH_PLUS || junk == CH_MINUS ||
                    junk == CH_RIGHT || junk == CH_LEFT || junk == CH_COPY ||
                    junk == CH_OPEN || junk == CH_CLOSE || junk == CH_OUT ||
                    junk == CH_IN || junk == CH_SYS || junk == CH_LOAD);
                put(CMD_APPEND, junk, rand_word());
                filled++;
            end
            default: begin
                k = $urandom_range(0, 3);
                s = io.substr(k, k);
            end
        endcase
        if (s.len() != 0) send_text(s);
    endtask

    initial begin
        logic [63:0] init_choices [5];
        int phase;
        init_choices = '{64'd0, '1, 64'd1, 64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: cell zero shows the register; load, read sign extension,
        // syscall words, wrap both ways, resume with nothing pending, no-op item
        set_init('1);
        send_text("<.*,+!>-.,+.");
        put(CMD_START, 8'h00, 64'd0);
        put(CMD_RESUME, 8'hFF, '1);                      // after a write: ignored
        put(CMD_RESUME, 8'h00, 64'h7FFF_FFFF_FFFF_FFFF); // load answer
        put(CMD_RESUME, 8'h00, 64'h80);                  // read, negative byte
        put(CMD_RESUME, 8'h00, '1);                      // syscall answer
        put(CMD_RESUME, 8'h00, 64'd0);
        put(CMD_RESUME, 8'h00, 64'hFF);                  // read -1, then + wraps
        put(CMD_RESUME, 8'h00, 64'd0);
        put(CMD_RESUME, 8'hA5, 64'hDEAD);                // nothing pending
        put(CMD_NONE, 8'hFF, '1);
        wait_results();

        // random part: build, start, resume, and run to the end now and then
        phase = 0;
        while (items < 1500 && filled < 1300) begin
            if (items / 250 != phase) begin
                phase = items / 250;
                set_init((phase % 6 == 5) ? {$urandom, $urandom} : init_choices[phase % 5]);
            end
            case ($urandom_range(0, 19))
                10, 11, 12: put(CMD_START, 8'($urandom), rand_word());
                13, 14, 15, 16, 17: put(CMD_RESUME, 8'($urandom), rand_word());
                18: put(($urandom_range(0, 1) != 0) ? CMD_NONE : CMD_RESUME,
                        8'($urandom), rand_word());
                19: run_through(1'b1, '0);
                default: add_fragment();
            endcase
        end

        // tail, no idling: the fault cases
        calm = 1'b1;
        wait_results();
        // walk left incrementing: '<' at cell zero unless cell zero wraps to 0
        send_text("+[<+]");
        set_init(64'd0);
        run_through(1'b0, 64'd0);
        set_init('1);
        run_through(1'b0, 64'd0);
        // load picks: 0 stray ']' (backward scan past the start),
        // 1 copy walk off the end, 2 pointer walk off the last cell
        send_text("*[-[>+[>+]]+[=>+]]]");
        run_through(1'b0, 64'd0);
        run_through(1'b0, 64'd1);
        run_through(1'b0, 64'd2);
        // fill the program store past its depth; extra bytes are dropped
        while (filled < PROGRAM_DEPTH_DEF + 8) begin
            put(CMD_APPEND, 8'h20, rand_word());
            filled++;
        end
        run_through(1'b0, 64'd0);

        wait_results();
        repeat (64) @(negedge clk);
        if (errors == 0 && n_waiting == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/tlm_pkg.sv
src/tlm_datapath.sv
src/tlm_controller.sv
src/tape_language_machine.sv
test/tlm_checker.sv
test/tb.sv
